[hdl/assert_macros.svh]
// assertion helpers, clock clk and reset arst_n taken from the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hdl/ewci_pkg.sv]
package ewci_pkg;

	localparam int WINDOWS  = 4;
	localparam int CHANNELS = 256;

	localparam int TIME_W   = 32;
	localparam int CHARGE_W = 24;
	localparam int SUM_W    = 40;
	localparam int LANE_W   = 16;
	localparam int CNT_W    = 3;
	localparam int WIDX_W   = 2;
	localparam int ALU_W    = 34;
	localparam int OFS_W    = 33;

	localparam logic [1:0] CMD_BEGIN  = 2'd0;
	localparam logic [1:0] CMD_PULSE  = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	localparam logic [2:0] REG_WINDOW_COUNT  = 3'd0;
	localparam logic [2:0] REG_WINDOW_LIMITS = 3'd1;
	localparam logic [2:0] REG_CHAN_MASK_0   = 3'd2;
	localparam logic [2:0] REG_CHAN_MASK_3   = 3'd5;

	localparam logic [CNT_W-1:0] WIN_MAX = CNT_W'(WINDOWS);

	typedef struct packed {
		logic [1:0]                 cmd;
		logic signed [TIME_W-1:0]   event_start;
		logic signed [TIME_W-1:0]   event_end;
		logic signed [TIME_W-1:0]   pulse_time;
		logic [CHARGE_W-1:0]        pulse_charge;
		logic [7:0]                 channel;
	} item_t;

	typedef struct packed {
		logic [WIDX_W-1:0] window_index;
		logic [SUM_W-1:0]  charge_total;
		logic              last_total;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0]  n_win;
		logic [LANE_W-1:0] lane;
		logic              chan_en;
	} cfg_view_t;

endpackage

[hdl/ewci_cfg.sv]
module ewci_cfg
	import ewci_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_idx,
	input  logic [63:0]       cfg_data,
	input  logic [7:0]        channel,
	input  logic [WIDX_W-1:0] lane_sel,
	output cfg_view_t         view
);

	logic [CNT_W-1:0] win_count_q;
	logic [63:0]      limits_q;
	logic [63:0]      mask_q [4];
	logic [1:0]       mask_sel;

	assign mask_sel = 2'(cfg_idx - REG_CHAN_MASK_0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_count_q <= CNT_W'(1);
			limits_q    <= 64'd1440;
			for (int i = 0; i < 4; i++) begin
				mask_q[i] <= '1;
			end
		end else if (cfg_we) begin
			if (cfg_idx == REG_WINDOW_COUNT) begin
				win_count_q <= cfg_data[CNT_W-1:0];
			end else if (cfg_idx == REG_WINDOW_LIMITS) begin
				limits_q <= cfg_data;
			end else if (cfg_idx inside {[REG_CHAN_MASK_0:REG_CHAN_MASK_3]}) begin
				mask_q[mask_sel] <= cfg_data;
			end
		end
	end

	always_comb begin
		if (win_count_q == '0) begin
			view.n_win = CNT_W'(1);
		end else if (win_count_q > WIN_MAX) begin
			view.n_win = WIN_MAX;
		end else begin
			view.n_win = win_count_q;
		end
		view.lane    = limits_q[LANE_W*lane_sel +: LANE_W];
		view.chan_en = ({1'b0, channel} < 9'(CHANNELS)) && mask_q[channel[7:6]][channel[5:0]];
	end

endmodule

[hdl/event_window_charge_integrator.sv]
// sequence: begin is taken in idle; pulse runs accept, start check, end check, one window
//   step per limit crossed plus one, charge add; finish runs accept, one fill step per open
//   window, hand-over, then one total per cycle while result_ready is high
// throughput: one word at a time, limited by the shared 34-bit compare unit and window walk
// reset: arst_n asynchronous active low; registers take their listed reset values, sums,
//   times and window totals clear, no result pending
module event_window_charge_integrator
	import ewci_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [63:0] cfg_data,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result
);

	`include "assert_macros.svh"

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_START = 7'b0000010,
		ST_END   = 7'b0000100,
		ST_WIN   = 7'b0001000,
		ST_ADD   = 7'b0010000,
		ST_FILL  = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t                   state_q;
	item_t                    item_q;
	logic signed [TIME_W-1:0] start_q;
	logic signed [TIME_W-1:0] end_q;
	logic [SUM_W-1:0]         sum_q;
	logic [CNT_W-1:0]         pos_q;
	logic                     stopped_q;
	logic [SUM_W-1:0]         totals_q [WINDOWS];
	logic [OFS_W-1:0]         offset_q;
	logic [CNT_W-1:0]         k_q;
	logic                     res_valid_q;
	result_t                  res_q;

	cfg_view_t                view;
	logic [WIDX_W-1:0]        lane_sel;
	logic signed [ALU_W-1:0]  op_a;
	logic signed [ALU_W-1:0]  op_b;
	logic signed [ALU_W-1:0]  diff;
	logic                     neg;
	logic [SUM_W:0]           sum_next;
	logic                     emit_load;
	logic                     emit_last;

	assign lane_sel = pos_q[WIDX_W-1:0];

	ewci_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.channel  (item_q.channel),
		.lane_sel (lane_sel),
		.view     (view)
	);

	// shared compare unit
	always_comb begin
		case (state_q)
			ST_START: begin
				op_a = ALU_W'(item_q.pulse_time);
				op_b = ALU_W'(start_q);
			end
			ST_END: begin
				op_a = ALU_W'(end_q);
				op_b = ALU_W'(item_q.pulse_time);
			end
			ST_WIN: begin
				op_a = {{(ALU_W-LANE_W){1'b0}}, view.lane};
				op_b = {1'b0, offset_q};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign diff = op_a - op_b;
	assign neg  = diff[ALU_W-1];

	assign sum_next  = {1'b0, sum_q} + {{(SUM_W+1-CHARGE_W){1'b0}}, item_q.pulse_charge};
	assign emit_load = (state_q == ST_EMIT) && (!res_valid_q || result_ready);
	assign emit_last = (k_q + CNT_W'(1)) == view.n_win;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			start_q   <= '0;
			end_q     <= '0;
			sum_q     <= '0;
			pos_q     <= '0;
			stopped_q <= 1'b0;
			k_q       <= '0;
			for (int i = 0; i < WINDOWS; i++) begin
				totals_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						case (item.cmd)
							CMD_BEGIN: begin
								start_q   <= item.event_start;
								end_q     <= item.event_end;
								sum_q     <= '0;
								pos_q     <= '0;
								stopped_q <= 1'b0;
								for (int i = 0; i < WINDOWS; i++) begin
									totals_q[i] <= '0;
								end
							end
							CMD_PULSE:  state_q <= ST_START;
							CMD_FINISH: state_q <= ST_FILL;
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_START: begin
					if (stopped_q || !view.chan_en || neg) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_END;
					end
				end
				ST_END: begin
					if (neg) begin
						stopped_q <= 1'b1;
						state_q   <= ST_IDLE;
					end else begin
						state_q <= ST_WIN;
					end
				end
				ST_WIN: begin
					if (pos_q < view.n_win && neg) begin
						totals_q[lane_sel] <= sum_q;
						pos_q              <= pos_q + CNT_W'(1);
					end else if (pos_q >= view.n_win) begin
						stopped_q <= 1'b1;
						state_q   <= ST_IDLE;
					end else begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					sum_q   <= sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
					state_q <= ST_IDLE;
				end
				ST_FILL: begin
					if (pos_q < view.n_win) begin
						totals_q[lane_sel] <= sum_q;
						pos_q              <= pos_q + CNT_W'(1);
					end else begin
						stopped_q <= 1'b1;
						k_q       <= '0;
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						k_q <= k_q + CNT_W'(1);
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// captured word, offset of the pulse from the start kept for the window walk, and result word
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			item_q <= item;
		end
		if (state_q == ST_START) begin
			offset_q <= diff[OFS_W-1:0];
		end
		if (emit_load) begin
			res_q.window_index <= k_q[WIDX_W-1:0];
			res_q.charge_total <= totals_q[k_q[WIDX_W-1:0]];
			res_q.last_total   <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_load) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	`ASSERT_IMPL(a_pos_bounded, 1'b1, pos_q <= WIN_MAX)
	`ASSERT_NEXT(a_last_ends_emit, emit_load && emit_last, state_q == ST_IDLE)
	`ASSERT_NEXT(a_sum_grows, state_q == ST_ADD, sum_q >= $past(sum_q))
	`ASSERT_IMPL(a_stop_from_work, $rose(stopped_q), $past(state_q) != ST_IDLE)

endmodule

[tb/event_window_charge_integrator_test.sv]
`timescale 1ns / 100ps

module event_window_charge_integrator_test;
	import ewci_pkg::*;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam longint T_MAX = (64'sd1 <<< 31) - 1;
	localparam longint T_MIN = -(64'sd1 <<< 31);
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_idx = '0;
	logic [63:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;

	event_window_charge_integrator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #10 clk = ~clk;

	// register copies
	logic [2:0] cfg_count = 3'd1;
	logic [63:0] cfg_limits = 64'd1440;
	logic [63:0] cfg_mask [4] = '{default: '1};

	// integrator state
	longint ev_start = 0;
	longint ev_end = 0;
	logic [SUM_W-1:0] acc_sum = '0;
	int next_win = 0;
	bit halted = 1'b0;
	logic [SUM_W-1:0] win_total [4] = '{default: '0};

	item_t pending_words [$];
	result_t totals_due [$];
	int queued = 0;
	int errors = 0;
	int idle_cycles = 0;
	int send_pct = 0;
	int recv_pct = 0;
	int send_gap = 0;
	int recv_gap = 0;
	bit hold_req = 1'b0;
	int hold_cnt = 0;
	logic item_taken = 1'b0;

	task automatic integrate_word(input item_t w);
		int n;
		longint t;
		longint ofs;
		logic [SUM_W:0] s;
		result_t r;
		n = cfg_count;
		if (n < 1) n = 1;
		if (n > WINDOWS) n = WINDOWS;
		case (w.cmd)
			CMD_BEGIN: begin
				ev_start = $signed(w.event_start);
				ev_end = $signed(w.event_end);
				acc_sum = '0;
				next_win = 0;
				halted = 1'b0;
				for (int k = 0; k < 4; k++) win_total[k] = '0;
			end
			CMD_PULSE: begin
				t = $signed(w.pulse_time);
				if (!halted && cfg_mask[w.channel[7:6]][w.channel[5:0]] && t >= ev_start) begin
					if (t > ev_end) begin
						halted = 1'b1;
					end else begin
						ofs = t - ev_start;
						while (next_win < n && ofs > longint'(cfg_limits[16*next_win +: 16])) begin
							win_total[next_win] = acc_sum;
							next_win++;
						end
						if (next_win >= n) begin
							halted = 1'b1;
						end else begin
							s = acc_sum + w.pulse_charge;
							acc_sum = s[SUM_W] ? '1 : s[SUM_W-1:0];
						end
					end
				end
			end
			CMD_FINISH: begin
				while (next_win < n) begin
					win_total[next_win] = acc_sum;
					next_win++;
				end
				halted = 1'b1;
				for (int k = 0; k < n; k++) begin
					r.window_index = WIDX_W'(k);
					r.charge_total = win_total[k];
					r.last_total = (k == n - 1);
					totals_due = {totals_due, r};
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_total(input result_t got);
		result_t want;
		if (totals_due.size() == 0) begin
			$display("%0t ns: total with none expected: window %0d total %h last %b",
				$time, got.window_index, got.charge_total, got.last_total);
			errors++;
		end else begin
			want = totals_due.pop_front();
			if (got.window_index !== want.window_index) begin
				$display("%0t ns: window_index expected %0d got %0d",
					$time, want.window_index, got.window_index);
				errors++;
			end
			if (got.charge_total !== want.charge_total) begin
				$display("%0t ns: charge_total expected %h got %h",
					$time, want.charge_total, got.charge_total);
				errors++;
			end
			if (got.last_total !== want.last_total) begin
				$display("%0t ns: last_total expected %b got %b",
					$time, want.last_total, got.last_total);
				errors++;
			end
		end
	endtask

	always @(posedge clk) begin
		item_taken <= arst_n && item_valid && item_ready;
		if (arst_n) begin
			if (item_valid && item_ready) integrate_word(item);
			if (result_valid && result_ready) check_total(result);
			if ((item_valid && item_ready) || (result_valid && result_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
					$display("== FAIL ==");
					$finish;
				end
			end
		end
	end

	// word driver
	always @(negedge clk) begin
		if (arst_n && (!item_valid || item_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				item_valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				item <= pending_words.pop_front();
				item_valid <= 1'b1;
				if (send_pct != 0 && $urandom_range(99) < send_pct)
					send_gap = $urandom_range(1, 13);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req && hold_cnt < HOLD_CYCLES) begin
				hold_cnt++;
				result_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				result_ready <= 1'b0;
			end else if (recv_pct != 0 && $urandom_range(99) < recv_pct) begin
				recv_gap = $urandom_range(0, 12);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	function automatic longint clamp32(input longint v);
		if (v > T_MAX) return T_MAX;
		if (v < T_MIN) return T_MIN;
		return v;
	endfunction

	function automatic item_t random_word(input logic [1:0] op);
		item_t w;
		w.cmd = op;
		w.event_start = $urandom();
		w.event_end = $urandom();
		w.pulse_time = $urandom();
		w.pulse_charge = 24'($urandom());
		w.channel = 8'($urandom());
		return w;
	endfunction

	task automatic push_word(input item_t w);
		pending_words = {pending_words, w};
		queued++;
	endtask

	task automatic queue_begin(input logic [31:0] s, input logic [31:0] e);
		item_t w;
		w = random_word(CMD_BEGIN);
		w.event_start = s;
		w.event_end = e;
		push_word(w);
	endtask

	task automatic queue_pulse(input logic [31:0] t, input logic [23:0] q, input logic [7:0] ch);
		item_t w;
		w = random_word(CMD_PULSE);
		w.pulse_time = t;
		w.pulse_charge = q;
		w.channel = ch;
		push_word(w);
	endtask

	task automatic queue_finish();
		push_word(random_word(CMD_FINISH));
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			REG_WINDOW_COUNT: cfg_count = val[2:0];
			REG_WINDOW_LIMITS: cfg_limits = val;
			default: if (idx >= REG_CHAN_MASK_0 && idx <= REG_CHAN_MASK_3)
				cfg_mask[idx - REG_CHAN_MASK_0] = val;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_words.size() != 0 || item_valid || totals_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic pick_setup();
		logic [2:0] cnt;
		logic [63:0] lim;
		logic [63:0] m;
		int a;
		case ($urandom_range(5))
			0: cnt = 3'd0;
			1: cnt = 3'd7;
			2: cnt = 3'd1;
			3: cnt = 3'd4;
			default: cnt = 3'($urandom_range(1, 4));
		endcase
		write_reg(REG_WINDOW_COUNT, {$urandom(), 29'($urandom()), cnt});
		case ($urandom_range(5))
			0: lim = '0;
			1: lim = '1;
			2: lim = {$urandom(), $urandom()};
			default: begin
				a = $urandom_range(1500);
				for (int k = 0; k < 4; k++) begin
					if (a > 65535) a = 65535;
					lim[16*k +: 16] = 16'(a);
					a += $urandom_range(6000);
				end
			end
		endcase
		write_reg(REG_WINDOW_LIMITS, lim);
		for (int k = 0; k < 4; k++) begin
			case ($urandom_range(4))
				0: m = '1;
				1: m = '0;
				2: m = {$urandom(), $urandom()};
				default: m = {$urandom(), $urandom()} | {$urandom(), $urandom()};
			endcase
			write_reg(3'(REG_CHAN_MASK_0 + k), m);
		end
	endtask

	task automatic queue_event(input int max_pulses, input bit with_begin, input bit with_finish);
		longint s;
		longint e;
		longint t;
		int np;
		case ($urandom_range(9))
			0: s = longint'($signed($urandom()));
			1: s = T_MIN + longint'($urandom_range(100));
			2: s = T_MAX - longint'($urandom_range(100000));
			default: s = longint'($urandom_range(1000000)) - 500000;
		endcase
		case ($urandom_range(7))
			0: e = s - longint'($urandom_range(1, 100));
			1: e = T_MAX;
			default: e = clamp32(s + longint'($urandom_range(80000)));
		endcase
		if (with_begin) queue_begin(32'(s), 32'(clamp32(e)));
		t = s;
		if ($urandom_range(3) == 0) t = clamp32(t - longint'($urandom_range(1, 50)));
		np = $urandom_range(max_pulses);
		repeat (np) begin
			case ($urandom_range(9))
				0, 1: t += longint'($urandom_range(3));
				2, 3: t += longint'($urandom_range(200));
				4, 5: t += longint'($urandom_range(3000));
				6, 7, 8: t += longint'($urandom_range(40000));
				default: t -= longint'($urandom_range(500));
			endcase
			t = clamp32(t);
			queue_pulse(32'(t), ($urandom_range(3) == 0) ? 24'hFF_FFFF : 24'($urandom()),
				8'($urandom()));
		end
		if (with_finish) begin
			queue_finish();
			if ($urandom_range(9) == 0) queue_finish();
		end
	endtask

	task automatic queue_phase(input int words);
		int first;
		first = queued;
		while (queued - first < words) begin
			case ($urandom_range(11))
				0: push_word(random_word(2'($urandom_range(3))));
				1: queue_event(6, 1'b1, 1'b0);
				2: queue_event(6, 1'b0, 1'b1);
				default: queue_event(10, 1'b1, 1'b1);
			endcase
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: one window with limit 1440, every channel on
		queue_pulse(32'd0, 24'hFF_FFFF, 8'd0);
		queue_pulse(32'hFFFF_FFFF, 24'd9, 8'd1);
		push_word(random_word(CMD_NONE));
		queue_pulse(32'd1, 24'd3, 8'd2);
		queue_finish();
		queue_finish();
		queue_begin(32'h8000_0000, 32'h7FFF_FFFF);
		queue_pulse(32'h8000_0000, 24'd1, 8'd255);
		queue_pulse(32'h8000_05A0, 24'd2, 8'd128);
		queue_pulse(32'h8000_05A1, 24'd4, 8'd64);
		queue_finish();
		drain();

		write_reg(REG_WINDOW_COUNT, 64'd4);
		write_reg(REG_WINDOW_LIMITS, 64'hFFFF_0640_0190_0064);
		write_reg(REG_CHAN_MASK_0, ~64'd1);
		write_reg(3'(REG_CHAN_MASK_0 + 1), '1);
		write_reg(3'(REG_CHAN_MASK_0 + 2), '0);
		write_reg(REG_CHAN_MASK_3, '1);
		queue_begin(32'd1000, 32'h7FFF_FFFF);
		queue_pulse(32'd1000, 24'd5, 8'd0);
		queue_pulse(32'd1000, 24'd5, 8'd150);
		queue_pulse(32'd1000, 24'd10, 8'd255);
		queue_pulse(32'd1101, 24'd20, 8'd64);
		queue_pulse(32'd3000, 24'd40, 8'd100);
		queue_pulse(32'd66535, 24'd80, 8'd200);
		queue_pulse(32'd66536, 24'd1, 8'd201);
		queue_pulse(32'd70000, 24'd1, 8'd202);
		queue_finish();
		queue_begin(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_pulse(32'h7FFF_FFFF, 24'd7, 8'd63);
		queue_finish();
		queue_begin(32'd5, 32'hFFFF_FFFB);
		queue_pulse(32'd5, 24'd9, 8'd70);
		queue_finish();
		drain();

		for (int p = 0; p < 6; p++) begin
			pick_setup();
			send_pct = (p % 3) * 20;
			recv_pct = ((p + 1) % 3) * 20;
			if (p == 2) begin
				send_pct = 0;
				hold_req = 1'b1;
			end
			queue_phase(60);
			drain();
		end

		// full-scale charges back to back
		send_pct = 0;
		recv_pct = 0;
		write_reg(REG_WINDOW_COUNT, 64'd2);
		write_reg(REG_WINDOW_LIMITS, '1);
		for (int k = 0; k < 4; k++) write_reg(3'(REG_CHAN_MASK_0 + k), '1);
		queue_begin(32'd0, 32'd0);
		repeat (12) queue_pulse(32'd0, 24'hFF_FFFF, 8'($urandom()));
		queue_finish();
		drain();

		pick_setup();
		queue_phase(30);
		drain();

		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
